// File: src/pbof_pkg.sv
// Shared types and constants for the pairwise box overlap filter.
// Used by the controller, the datapath and the top level; no dependencies.
package pbof_pkg;

	localparam int IDX_W    = 4;
	localparam int HELD_W   = 5;
	localparam int COORD_W  = 16;
	localparam int EXTENT_W = 15;
	localparam int KIND_W   = 3;
	localparam int MASK_W   = 64;
	localparam int CFG_W    = 64;
	localparam int TYPE_COUNT = 8;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SCAN   = 2'd2;

	localparam logic REG_TYPE_PAIR_MASK = 1'b0;
	localparam logic REG_TRIGGER_TYPE   = 1'b1;

	localparam logic [KIND_W-1:0] TRIGGER_RESET = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [EXTENT_W-1:0] h;
		logic [EXTENT_W-1:0] w;
		logic [COORD_W-1:0]  y;
		logic [COORD_W-1:0]  x;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef struct packed {
		logic accept;
		logic load_i;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_start;
		logic out_free;
		logic block;
		logic scan_done;
	} status_t;

endpackage

// File: src/pbof_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pbof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/pbof_ctrl.sv
// Sequencing state machine for the box overlap filter.
// Depends on pbof_pkg for the command and status structs.
module pbof_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pbof_pkg::status_t st,
	output pbof_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign item_stall = !((state_q == S_IDLE) && st.out_free);

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && item_valid && st.out_free;
		cmd.load_i = (state_q == S_FETCH);
		cmd.step   = (state_q == S_SCAN) && !st.scan_done && (!st.block || st.out_free);
		cmd.finish = (state_q == S_SCAN) && st.scan_done && st.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept && st.scan_start) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cmd.finish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/pbof_dp.sv
// Datapath of the box overlap filter: box store, held count, configuration
// registers, the overlap test and the result register. Uses pbof_pkg and pbof_ram.
module pbof_dp #(
	parameter int MAX_BOXES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pbof_pkg::cmd_t                      cmd,
	output pbof_pkg::status_t                   st,
	input  logic                                cfg_wen,
	input  logic                                cfg_index,
	input  logic [pbof_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [1:0]                          opcode,
	input  logic signed [pbof_pkg::COORD_W-1:0] box_x,
	input  logic signed [pbof_pkg::COORD_W-1:0] box_y,
	input  logic [pbof_pkg::EXTENT_W-1:0]       box_w,
	input  logic [pbof_pkg::EXTENT_W-1:0]       box_h,
	input  logic [pbof_pkg::KIND_W-1:0]         box_kind,
	input  logic [pbof_pkg::IDX_W-1:0]          scan_index,
	input  logic                                result_stall,
	output logic                                result_valid,
	output logic                                pair_found,
	output logic [pbof_pkg::IDX_W-1:0]          first_index,
	output logic [pbof_pkg::IDX_W-1:0]          second_index,
	output logic                                to_scene,
	output logic                                list_full,
	output logic [pbof_pkg::HELD_W-1:0]         entry_count,
	output logic                                last_result
);

	localparam int AW = $clog2(MAX_BOXES);

	logic [pbof_pkg::MASK_W-1:0] mask_q;
	logic [pbof_pkg::KIND_W-1:0] trigger_q;
	logic [pbof_pkg::HELD_W-1:0] held_q, held_d;
	logic [pbof_pkg::IDX_W-1:0]  i_q;
	pbof_pkg::box_t              bi_q;
	logic [pbof_pkg::HELD_W-1:0] j_q;
	logic                        cmp_v_q;
	logic [pbof_pkg::HELD_W-1:0] cmp_j_q;
	logic                        pend_v_q;
	logic [pbof_pkg::IDX_W-1:0]  pend_j_q;
	logic                        pend_scene_q;
	logic                        out_valid_q;

	logic                        is_full;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_raddr;
	pbof_pkg::box_t              wr_box, bj;
	logic [pbof_pkg::BOX_W-1:0]  ram_rdata;

	logic signed [16:0]          xi, yi, wi, hi, xj, yj, wj, hj;
	logic                        separated, pair_ok, scene, hit;

	logic                        out_load;
	logic                        nx_found, nx_scene, nx_full, nx_last;
	logic [pbof_pkg::IDX_W-1:0]  nx_first, nx_second;

	assign is_full = (held_q >= pbof_pkg::HELD_W'(MAX_BOXES));

	always_comb begin
		st.scan_start = (opcode == pbof_pkg::OP_SCAN) && ({1'b0, scan_index} < held_q);
		st.out_free   = !out_valid_q || !result_stall;
		st.block      = hit && pend_v_q;
		st.scan_done  = !cmp_v_q && (j_q >= held_q);
	end

	// Box store: written on append, read for box i at scan start and then
	// for each later box j in turn.
	assign wr_box = '{kind: box_kind, h: box_h, w: box_w, y: box_y, x: box_x};
	assign ram_we = cmd.accept && (opcode == pbof_pkg::OP_APPEND) && !is_full;
	assign ram_re = (cmd.accept && st.scan_start) || (cmd.step && (j_q < held_q));
	assign ram_raddr = cmd.accept ? scan_index[AW-1:0] : j_q[AW-1:0];

	pbof_ram #(
		.WIDTH(pbof_pkg::BOX_W),
		.DEPTH(MAX_BOXES)
	) u_box_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(held_q[AW-1:0]),
		.wdata(wr_box),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign bj = pbof_pkg::box_t'(ram_rdata);

	// Edge tests at 17 bits signed; the sums cannot overflow.
	always_comb begin
		xi = {bi_q.x[15], bi_q.x};
		yi = {bi_q.y[15], bi_q.y};
		wi = {2'b00, bi_q.w};
		hi = {2'b00, bi_q.h};
		xj = {bj.x[15], bj.x};
		yj = {bj.y[15], bj.y};
		wj = {2'b00, bj.w};
		hj = {2'b00, bj.h};
		separated = (yj + hj <= yi) || (yj >= yi + hi) || (xj + wj <= xi) || (xj >= xi + wi);
		pair_ok = (int'(bi_q.kind) < pbof_pkg::TYPE_COUNT)
			&& (int'(bj.kind) < pbof_pkg::TYPE_COUNT)
			&& mask_q[{bi_q.kind, bj.kind}];
		scene = (bi_q.kind == trigger_q) || (bj.kind == trigger_q);
		hit = cmp_v_q && !separated && pair_ok;
	end

	always_comb begin
		held_d = held_q;
		if (cmd.accept && (opcode == pbof_pkg::OP_CLEAR)) begin
			held_d = '0;
		end else if (ram_we) begin
			held_d = held_q + 1'b1;
		end
	end

	// A hit is held back until the next hit or the end of the scan, so that the final one can carry last_result.
	always_comb begin
		out_load  = 1'b0;
		nx_found  = 1'b0;
		nx_first  = '0;
		nx_second = '0;
		nx_scene  = 1'b0;
		nx_full   = 1'b0;
		nx_last   = 1'b1;
		priority if (cmd.accept && !st.scan_start) begin
			out_load = 1'b1;
			nx_full  = (opcode == pbof_pkg::OP_APPEND) && is_full;
		end else if (cmd.step && hit && pend_v_q) begin
			out_load  = 1'b1;
			nx_found  = 1'b1;
			nx_first  = i_q;
			nx_second = pend_j_q;
			nx_scene  = pend_scene_q;
			nx_last   = 1'b0;
		end else if (cmd.finish) begin
			out_load = 1'b1;
			if (pend_v_q) begin
				nx_found  = 1'b1;
				nx_first  = i_q;
				nx_second = pend_j_q;
				nx_scene  = pend_scene_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			trigger_q   <= pbof_pkg::TRIGGER_RESET;
			held_q      <= '0;
			j_q         <= '0;
			cmp_v_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					pbof_pkg::REG_TYPE_PAIR_MASK: mask_q <= cfg_wdata;
					pbof_pkg::REG_TRIGGER_TYPE: trigger_q <= cfg_wdata[pbof_pkg::KIND_W-1:0];
					default: mask_q <= mask_q;
				endcase
			end
			held_q <= held_d;
			if (cmd.load_i) begin
				j_q      <= {1'b0, i_q} + 1'b1;
				cmp_v_q  <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (cmd.step) begin
				cmp_v_q <= ram_re;
				if (ram_re) begin
					j_q <= j_q + 1'b1;
				end
				if (hit) begin
					pend_v_q <= 1'b1;
				end
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			i_q <= scan_index;
		end
		if (cmd.load_i) begin
			bi_q <= bj;
		end
		if (cmd.step) begin
			cmp_j_q <= j_q;
			if (hit) begin
				pend_j_q     <= cmp_j_q[pbof_pkg::IDX_W-1:0];
				pend_scene_q <= scene;
			end
		end
		if (out_load) begin
			pair_found   <= nx_found;
			first_index  <= nx_first;
			second_index <= nx_second;
			to_scene     <= nx_scene;
			list_full    <= nx_full;
			entry_count  <= held_d;
			last_result  <= nx_last;
		end
	end

	assign result_valid = out_valid_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= pbof_pkg::HELD_W'(MAX_BOXES))
		else $error("held count exceeds the store depth");

	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_q |-> (cmp_j_q < held_q) && (cmp_j_q > {1'b0, i_q}))
		else $error("compared entry lies outside the scanned range");

	a_pend_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (pend_j_q > i_q))
		else $error("pending pair is not ordered");

	a_found_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pair_found) |-> !list_full && (second_index > first_index))
		else $error("reported pair carries a full flag or bad order");

endmodule

// File: src/pairwise_box_overlap_filter_top.sv
// Pairwise box overlap filter: a list of up to MAX_BOXES boxes with pair scans.
// Clear, append and a scan whose index is not below the held count give a single result. A scan of box
// i over n held boxes compares one later box per cycle through the box RAM read port while no
// stalled result holds it back; a stalled result also holds back the last result of the scan.
// Reset (arst_n, asynchronous) empties the list, clears the pair mask and sets the trigger type
// to 5; box contents are undefined until appended.
module pairwise_box_overlap_filter_top #(
	parameter int MAX_BOXES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic                                cfg_index,
	input  logic [pbof_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [pbof_pkg::COORD_W-1:0] box_x,
	input  logic signed [pbof_pkg::COORD_W-1:0] box_y,
	input  logic [pbof_pkg::EXTENT_W-1:0]       box_w,
	input  logic [pbof_pkg::EXTENT_W-1:0]       box_h,
	input  logic [pbof_pkg::KIND_W-1:0]         box_kind,
	input  logic [pbof_pkg::IDX_W-1:0]          scan_index,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                pair_found,
	output logic [pbof_pkg::IDX_W-1:0]          first_index,
	output logic [pbof_pkg::IDX_W-1:0]          second_index,
	output logic                                to_scene,
	output logic                                list_full,
	output logic [pbof_pkg::HELD_W-1:0]         entry_count,
	output logic                                last_result
);

	pbof_pkg::cmd_t    cmd;
	pbof_pkg::status_t st;

	pbof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.st        (st),
		.cmd       (cmd)
	);

	pbof_dp #(
		.MAX_BOXES(MAX_BOXES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.opcode      (opcode),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.box_kind    (box_kind),
		.scan_index  (scan_index),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.pair_found  (pair_found),
		.first_index (first_index),
		.second_index(second_index),
		.to_scene    (to_scene),
		.list_full   (list_full),
		.entry_count (entry_count),
		.last_result (last_result)
	);

endmodule

// File: sim/tb_pairwise_box_overlap_filter_top.sv
// Self-checking testbench for pairwise_box_overlap_filter_top: directed and random
// clear/append/scan traffic against a behavioral predictor, with random idling on both sides.
// Depends on pbof_pkg and the filter top level only.
module tb_pairwise_box_overlap_filter_top;

	localparam int         LIST_DEPTH   = 16;
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         DRAIN_CYCLES = 20;
	localparam int         CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [1:0]                    op;
		logic [pbof_pkg::COORD_W-1:0]  x;
		logic [pbof_pkg::COORD_W-1:0]  y;
		logic [pbof_pkg::EXTENT_W-1:0] w;
		logic [pbof_pkg::EXTENT_W-1:0] h;
		logic [pbof_pkg::KIND_W-1:0]   kind;
		logic [pbof_pkg::IDX_W-1:0]    idx;
		logic                          drain_first;
	} filter_cmd_t;

	typedef struct packed {
		logic                        found;
		logic [pbof_pkg::IDX_W-1:0]  first_idx;
		logic [pbof_pkg::IDX_W-1:0]  second_idx;
		logic                        scene;
		logic                        full;
		logic [pbof_pkg::HELD_W-1:0] count;
		logic                        last;
	} pair_report_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_wen = 1'b0;
	logic                                cfg_index = 1'b0;
	logic [pbof_pkg::CFG_W-1:0]          cfg_wdata = '0;
	logic                                item_valid = 1'b0;
	logic                                item_stall;
	logic [1:0]                          opcode = '0;
	logic signed [pbof_pkg::COORD_W-1:0] box_x = '0;
	logic signed [pbof_pkg::COORD_W-1:0] box_y = '0;
	logic [pbof_pkg::EXTENT_W-1:0]       box_w = '0;
	logic [pbof_pkg::EXTENT_W-1:0]       box_h = '0;
	logic [pbof_pkg::KIND_W-1:0]         box_kind = '0;
	logic [pbof_pkg::IDX_W-1:0]          scan_index = '0;
	logic                                result_valid;
	logic                                result_stall = 1'b0;
	logic                                pair_found;
	logic [pbof_pkg::IDX_W-1:0]          first_index;
	logic [pbof_pkg::IDX_W-1:0]          second_index;
	logic                                to_scene;
	logic                                list_full;
	logic [pbof_pkg::HELD_W-1:0]         entry_count;
	logic                                last_result;

	// Predictor state: its own copy of the box list and the registers.
	pbof_pkg::box_t              kept_box [LIST_DEPTH];
	int                          kept_count = 0;
	logic [pbof_pkg::MASK_W-1:0] pair_mask = '0;
	logic [pbof_pkg::KIND_W-1:0] scene_kind = pbof_pkg::TRIGGER_RESET;

	filter_cmd_t  cmds_to_send [$];
	pair_report_t reports_due [$];
	filter_cmd_t  cmd_on_bus;
	logic         item_sent = 1'b0;
	int           send_gap = 0;
	int           stall_left = 0;
	bit           gap_mode = 1'b1;
	bit           stall_mode = 1'b1;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	pairwise_box_overlap_filter_top #(.MAX_BOXES(LIST_DEPTH)) uut (.*);

	always #5 clk = ~clk;

	function automatic void queue_cmd(input filter_cmd_t c);
		cmds_to_send.insert(cmds_to_send.size(), c);
	endfunction

	function automatic void expect_report(input pair_report_t r);
		reports_due.insert(reports_due.size(), r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic pair_report_t make_report(input logic found, input int fi, input int si,
			input logic scene, input logic full, input logic last);
		pair_report_t r;
		r.found      = found;
		r.first_idx  = fi[pbof_pkg::IDX_W-1:0];
		r.second_idx = si[pbof_pkg::IDX_W-1:0];
		r.scene      = scene;
		r.full       = full;
		r.count      = kept_count[pbof_pkg::HELD_W-1:0];
		r.last       = last;
		return r;
	endfunction

	// Edge tests at full integer width, so the 17-bit sums never wrap.
	function automatic bit rects_intersect(input int a, input int b);
		int xi, yi, wi, hi, xj, yj, wj, hj;
		xi = int'($signed(kept_box[a].x));
		yi = int'($signed(kept_box[a].y));
		wi = int'(kept_box[a].w);
		hi = int'(kept_box[a].h);
		xj = int'($signed(kept_box[b].x));
		yj = int'($signed(kept_box[b].y));
		wj = int'(kept_box[b].w);
		hj = int'(kept_box[b].h);
		if (yj + hj <= yi)
			return 1'b0;
		if (yj >= yi + hi)
			return 1'b0;
		if (xj + wj <= xi)
			return 1'b0;
		if (xj >= xi + wi)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic void compute_reports(input filter_cmd_t c);
		int i, j, ta, tb;
		pair_report_t held_back;
		bit holding;
		logic scene;
		holding = 1'b0;
		case (c.op)
			pbof_pkg::OP_CLEAR: begin
				kept_count = 0;
				expect_report(make_report(1'b0, 0, 0, 1'b0, 1'b0, 1'b1));
			end
			pbof_pkg::OP_APPEND: begin
				if (kept_count >= LIST_DEPTH) begin
					expect_report(make_report(1'b0, 0, 0, 1'b0, 1'b1, 1'b1));
				end else begin
					kept_box[kept_count] = '{kind: c.kind, h: c.h, w: c.w, y: c.y, x: c.x};
					kept_count++;
					expect_report(make_report(1'b0, 0, 0, 1'b0, 1'b0, 1'b1));
				end
			end
			pbof_pkg::OP_SCAN: begin
				i = int'(c.idx);
				for (j = i + 1; j < kept_count; j++) begin
					ta = int'(kept_box[i].kind);
					tb = int'(kept_box[j].kind);
					if (rects_intersect(i, j) && ta < pbof_pkg::TYPE_COUNT &&
							tb < pbof_pkg::TYPE_COUNT && pair_mask[ta * 8 + tb]) begin
						scene = (ta == scene_kind) || (tb == scene_kind);
						if (holding)
							expect_report(held_back);
						held_back = make_report(1'b1, i, j, scene, 1'b0, 1'b0);
						holding = 1'b1;
					end
				end
				if (holding) begin
					held_back.last = 1'b1;
					expect_report(held_back);
				end else begin
					expect_report(make_report(1'b0, 0, 0, 1'b0, 1'b0, 1'b1));
				end
			end
			default: begin
				expect_report(make_report(1'b0, 0, 0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [4:0] want,
			input logic [4:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Unused fields carry random values so that every input bit toggles.
	function automatic filter_cmd_t random_box();
		filter_cmd_t c;
		c.op          = pbof_pkg::OP_APPEND;
		c.kind        = pbof_pkg::KIND_W'($urandom);
		c.idx         = pbof_pkg::IDX_W'($urandom);
		c.drain_first = 1'b0;
		if ($urandom_range(0, 4) != 0) begin
			c.x = pbof_pkg::COORD_W'(int'($urandom_range(0, 80)) - 40);
			c.y = pbof_pkg::COORD_W'(int'($urandom_range(0, 80)) - 40);
			c.w = pbof_pkg::EXTENT_W'($urandom_range(0, 50));
			c.h = pbof_pkg::EXTENT_W'($urandom_range(0, 50));
		end else begin
			c.x = pbof_pkg::COORD_W'($urandom);
			c.y = pbof_pkg::COORD_W'($urandom);
			c.w = pbof_pkg::EXTENT_W'($urandom);
			c.h = pbof_pkg::EXTENT_W'($urandom);
		end
		return c;
	endfunction

	function automatic filter_cmd_t op_cmd(input logic [1:0] op, input int idx);
		filter_cmd_t c;
		c     = random_box();
		c.op  = op;
		c.idx = idx[pbof_pkg::IDX_W-1:0];
		return c;
	endfunction

	function automatic filter_cmd_t box_cmd(input int x, input int y, input int w, input int h,
			input int kind);
		filter_cmd_t c;
		c      = random_box();
		c.x    = x[pbof_pkg::COORD_W-1:0];
		c.y    = y[pbof_pkg::COORD_W-1:0];
		c.w    = w[pbof_pkg::EXTENT_W-1:0];
		c.h    = h[pbof_pkg::EXTENT_W-1:0];
		c.kind = kind[pbof_pkg::KIND_W-1:0];
		return c;
	endfunction

	// Checked at the rising edge, where the driver never pops an item.
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (cmds_to_send.size() != 0 || item_valid || reports_due.size() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [pbof_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == pbof_pkg::REG_TYPE_PAIR_MASK)
			pair_mask = data;
		else
			scene_kind = data[pbof_pkg::KIND_W-1:0];
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Mostly clear, fill and scan sequences; the rest is loose noise.
	task automatic queue_random_traffic(input int target, input bit force_full);
		int made, n, k, s, top;
		filter_cmd_t c;
		made = 0;
		while (made < target) begin
			if ($urandom_range(0, 99) < 85) begin
				s = $urandom_range(0, 99);
				if (force_full)
					n = 18;
				else if (s < 70)
					n = $urandom_range(2, 8);
				else if (s < 90)
					n = $urandom_range(9, 15);
				else
					n = $urandom_range(16, 19);
				force_full = 1'b0;
				if ($urandom_range(0, 9) != 0) begin
					c = op_cmd(pbof_pkg::OP_CLEAR, 0);
					c.drain_first = ($urandom_range(0, 7) == 0);
					queue_cmd(c);
					made++;
				end
				repeat (n) begin
					queue_cmd(random_box());
					made++;
				end
				top = (n > LIST_DEPTH) ? LIST_DEPTH - 1 : n - 1;
				k = $urandom_range(1, 6);
				repeat (k) begin
					if ($urandom_range(0, 4) != 0)
						queue_cmd(op_cmd(pbof_pkg::OP_SCAN, int'($urandom_range(0, top))));
					else
						queue_cmd(op_cmd(pbof_pkg::OP_SCAN, int'($urandom_range(0, 15))));
					made++;
				end
			end else begin
				c = random_box();
				c.op = 2'($urandom_range(0, 3));
				queue_cmd(c);
				if (c.op != OP_UNUSED)
					made++;
			end
		end
	endtask

	always @(negedge clk) begin : feed_items
		filter_cmd_t c;
		if (!(item_valid && !item_sent)) begin
			if (send_gap != 0) begin
				send_gap   <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (cmds_to_send.size() != 0 &&
					!(cmds_to_send[0].drain_first && reports_due.size() != 0)) begin
				c = cmds_to_send.pop_front();
				cmd_on_bus <= c;
				opcode     <= c.op;
				box_x      <= c.x;
				box_y      <= c.y;
				box_w      <= c.w;
				box_h      <= c.h;
				box_kind   <= c.kind;
				scan_index <= c.idx;
				item_valid <= 1'b1;
				send_gap   <= gap_mode ? pick_gap() : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (stall_mode && $urandom_range(0, 2) == 0)
				stall_left <= pick_gap();
		end
	end

	// Predict on each accepted input transaction before checking, so a same-edge result
	// always finds its expectation queued.
	always @(posedge clk) begin : watch_results
		pair_report_t want;
		if (!arst_n) begin
			item_sent <= 1'b0;
		end else begin
			item_sent <= item_valid && !item_stall;
			if (item_valid && !item_stall)
				compute_reports(cmd_on_bus);
			if (result_valid && !result_stall) begin
				if (reports_due.size() == 0) begin
					$error("result transaction with none outstanding");
					mismatch_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("pair_found", 5'(want.found), 5'(pair_found));
					check_field("first_index", 5'(want.first_idx), 5'(first_index));
					check_field("second_index", 5'(want.second_idx), 5'(second_index));
					check_field("to_scene", 5'(want.scene), 5'(to_scene));
					check_field("list_full", 5'(want.full), 5'(list_full));
					check_field("entry_count", want.count, entry_count);
					check_field("last_result", 5'(want.last), 5'(last_result));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_pairwise_box_overlap_filter_top: errors");
			$finish;
		end
	end

	initial begin
		int p;
		filter_cmd_t c;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: empty mask, so scans report nothing.
		queue_cmd(op_cmd(pbof_pkg::OP_CLEAR, 0));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 0));
		queue_cmd(box_cmd(-32768, -32768, 32767, 32767, 0));
		queue_cmd(box_cmd(32767, 32767, 32767, 32767, 7));
		queue_cmd(box_cmd(0, 0, 0, 0, 5));
		queue_cmd(box_cmd(-5, -5, 10, 10, 3));
		queue_cmd(op_cmd(OP_UNUSED, 0));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 0));
		wait_quiet();
		write_reg(pbof_pkg::REG_TYPE_PAIR_MASK, '1);
		end_writes();

		c = op_cmd(pbof_pkg::OP_SCAN, 0);
		c.drain_first = 1'b1;
		queue_cmd(c);
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 1));
		// A zero-size box inside another still counts as overlapping.
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 2));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 3));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 15));
		// Boxes that just touch an edge are separated.
		queue_cmd(box_cmd(5, -5, 4, 4, 1));
		queue_cmd(box_cmd(-9, -5, 4, 10, 5));
		queue_cmd(box_cmd(-6, -6, 12, 12, 2));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 0));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 3));
		queue_cmd(op_cmd(pbof_pkg::OP_CLEAR, 0));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 0));
		queue_cmd(box_cmd(1, 2, 3, 4, 6));
		queue_cmd(op_cmd(pbof_pkg::OP_SCAN, 0));
		queue_cmd(op_cmd(OP_UNUSED, 9));

		for (p = 0; p < 5; p++) begin
			wait_quiet();
			case (p)
				0: begin
					write_reg(pbof_pkg::REG_TYPE_PAIR_MASK, '1);
					write_reg(pbof_pkg::REG_TRIGGER_TYPE, 64'd0);
				end
				1: begin
					write_reg(pbof_pkg::REG_TYPE_PAIR_MASK, {$urandom, $urandom});
					write_reg(pbof_pkg::REG_TRIGGER_TYPE, 64'd7);
				end
				2: begin
					write_reg(pbof_pkg::REG_TYPE_PAIR_MASK, '0);
					write_reg(pbof_pkg::REG_TRIGGER_TYPE, 64'd3);
				end
				3: begin
					write_reg(pbof_pkg::REG_TYPE_PAIR_MASK, {$urandom, $urandom});
					write_reg(pbof_pkg::REG_TRIGGER_TYPE, 64'($urandom_range(0, 7)));
				end
				default: begin
					write_reg(pbof_pkg::REG_TYPE_PAIR_MASK,
						{$urandom & $urandom, $urandom & $urandom});
					write_reg(pbof_pkg::REG_TRIGGER_TYPE, 64'd5);
				end
			endcase
			end_writes();
			// Phase 1 runs with no idling on either side.
			gap_mode   = (p != 1);
			stall_mode = (p != 1);
			queue_random_traffic((p == 2) ? 40 : 100, p == 0);
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("tb_pairwise_box_overlap_filter_top: clean");
		else
			$display("tb_pairwise_box_overlap_filter_top: errors");
		$finish;
	end

endmodule

// File: filelist.f
src/pbof_pkg.sv
src/pbof_ram.sv
src/pbof_ctrl.sv
src/pbof_dp.sv
src/pairwise_box_overlap_filter_top.sv
sim/tb_pairwise_box_overlap_filter_top.sv
